// ===== sv/bfl_pkg.sv =====
// Shared types and constants for the byte FIFO with line extraction.
package bfl_pkg;

  // Item kinds selected by the mode field
  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_LINE  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_COPY_RD,
    S_COPY_LD,
    S_OUT
  } state_e;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [6:0] MAX_OUT      = 7'd64;
  localparam logic [6:0] MAX_LINE_RST = 7'd64;
  localparam logic [9:0] LEN_SAT      = 10'd1023;

  // Commands from controller to datapath
  typedef struct packed {
    logic    cap;        // capture item, base pointer and read count
    logic    push;       // store the write byte
    logic    commit_rd;  // pop the read count
    logic    clr;        // empty the FIFO
    logic    mem_rd;     // read the store at base + index
    logic    scan_step;  // advance the line scan
    logic    line_hit;   // LF found: set copy count, drop the line
    logic    idx_inc;    // advance the copy index
    logic    out_load;   // load the output register
    logic    out_data;   // output beat carries a data byte
    logic    out_echo;   // last echoes in_last
    logic    out_line;   // status taken from the line result
    status_e out_status; // status for a non-data beat
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  n_zero;
    logic  scan_end;
    logic  is_lf;
    logic  copy_zero;
    logic  out_taken;
    logic  more;
  } stat_t;

endpackage

// ===== sv/bfl_in_if.sv =====
// Input channel: valid/ready handshake with the item fields.
interface bfl_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] in_byte;
  logic       in_last;
  logic [6:0] count;

  modport source (output valid, mode, in_byte, in_last, count, input ready);
  modport sink   (input valid, mode, in_byte, in_last, count, output ready);
endinterface

// ===== sv/bfl_out_if.sv =====
// Output channel: valid/ready handshake with the result fields.
interface bfl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;
  logic [9:0]  line_len;
  logic [10:0] fill_level;

  modport source (output valid, out_byte, byte_valid, last, status, line_len,
                  fill_level, input ready);
  modport sink   (input valid, out_byte, byte_valid, last, status, line_len,
                  fill_level, output ready);
endinterface

// ===== sv/byte_fifo_with_line_extraction_core.sv =====
// A write, clear or single-status item shows its beat in the cycle after acceptance.
// Each read/peek byte takes a store read, a load and an output beat held until taken.
// A line scan reads and checks each byte, bounded by the fill level, before copying.
// One item is in flight at a time; input ready only while the controller is idle.
// Reset (async, active low) empties the FIFO and sets max_line to 64; store contents unset.
// Top level: byte FIFO with line extraction, controller plus datapath.
module byte_fifo_with_line_extraction_core #(
  parameter int DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  bfl_in_if.sink     in_i,
  bfl_out_if.source  out_o
);

  bfl_pkg::cmd_t  cmd;
  bfl_pkg::stat_t st;

  bfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bfl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (in_i.mode),
    .in_byte_i   (in_i.in_byte),
    .in_last_i   (in_i.in_last),
    .count_i     (in_i.count),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_o       (out_o)
  );

endmodule

// ===== sv/bfl_ctrl.sv =====
// Controller state machine: sequences writes, reads, line scans and beats.
module bfl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfl_pkg::stat_t st_i,
  output bfl_pkg::cmd_t  cmd_o
);

  bfl_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.out_status = bfl_pkg::ST_OK;
    case (state_q)
      bfl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          case (st_i.mode)
            bfl_pkg::MODE_WRITE: begin
              cmd_o.push       = !st_i.full;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_echo   = 1'b1;
              cmd_o.out_status = st_i.full ? bfl_pkg::ST_FULL : bfl_pkg::ST_OK;
              state_d          = bfl_pkg::S_OUT;
            end
            bfl_pkg::MODE_READ, bfl_pkg::MODE_PEEK: begin
              if (st_i.n_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = bfl_pkg::ST_NONE;
                state_d          = bfl_pkg::S_OUT;
              end else begin
                cmd_o.commit_rd = (st_i.mode == bfl_pkg::MODE_READ);
                state_d         = bfl_pkg::S_COPY_RD;
              end
            end
            bfl_pkg::MODE_LINE: begin
              state_d = bfl_pkg::S_SCAN_RD;
            end
            bfl_pkg::MODE_CLEAR: begin
              cmd_o.clr      = 1'b1;
              cmd_o.out_load = 1'b1;
              state_d        = bfl_pkg::S_OUT;
            end
            default: begin
              cmd_o.out_load = 1'b1;
              state_d        = bfl_pkg::S_OUT;
            end
          endcase
        end
      end
      bfl_pkg::S_SCAN_RD: begin
        if (st_i.scan_end) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = bfl_pkg::ST_NONE;
          state_d          = bfl_pkg::S_OUT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = bfl_pkg::S_SCAN_CHK;
        end
      end
      bfl_pkg::S_SCAN_CHK: begin
        if (st_i.is_lf) begin
          cmd_o.line_hit = 1'b1;
          if (st_i.copy_zero) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_line = 1'b1;
            state_d        = bfl_pkg::S_OUT;
          end else begin
            state_d = bfl_pkg::S_COPY_RD;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = bfl_pkg::S_SCAN_RD;
        end
      end
      bfl_pkg::S_COPY_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = bfl_pkg::S_COPY_LD;
      end
      bfl_pkg::S_COPY_LD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_data = 1'b1;
        state_d        = bfl_pkg::S_OUT;
      end
      bfl_pkg::S_OUT: begin
        if (st_i.out_taken) begin
          if (st_i.more) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = bfl_pkg::S_COPY_RD;
          end else begin
            state_d = bfl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = bfl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bfl_dp.sv =====
// Datapath: byte store, pointers, fill count, line scan and output register.
module bfl_dp #(
  parameter int DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic [2:0]     mode_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic [6:0]     count_i,
  input  bfl_pkg::cmd_t  cmd_i,
  output bfl_pkg::stat_t st_o,
  bfl_out_if.source      out_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int NW = (FW > 7) ? FW : 7;
  localparam int CW = (FW > 11) ? FW : 11;
  localparam logic [AW:0]   DEP      = (AW + 1)'(DEPTH);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

  // Wrap a pointer sum that stays below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= DEP) ? (s - DEP) : s;
    return t[AW-1:0];
  endfunction

  logic [7:0]       mem [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d, base_q, addr;
  logic [FW-1:0]    fill_q, fill_d, idx_q, idx_d, idx_p1;
  logic [6:0]       n_q, n_d, nreq, n_in, eff, copy, max_line_q;
  logic             prev_cr_q, prev_cr_d;
  logic [7:0]       rdata_q;
  logic [9:0]       len_q, len_d, len_line;
  bfl_pkg::status_e lstat_q, lstat_d, lstat_line;
  logic [CW-1:0]    content_x, fill_x;
  logic [FW-1:0]    content;
  logic             last_byte, more_q;

  // Output register
  logic             ov_q;
  logic [7:0]       obyte_q;
  logic             obv_q, olast_q;
  bfl_pkg::status_e ost_q;
  logic [9:0]       olen_q;
  logic [10:0]      ofill_q;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= bfl_pkg::MAX_LINE_RST;
    end else if (cfg_we_i) begin
      max_line_q <= cfg_wdata_i;
    end
  end

  // Effective line buffer size and read count
  always_comb begin
    if (max_line_q == 7'd0) begin
      eff = 7'd1;
    end else if (max_line_q > bfl_pkg::MAX_OUT) begin
      eff = bfl_pkg::MAX_OUT;
    end else begin
      eff = max_line_q;
    end
    nreq = (count_i > bfl_pkg::MAX_OUT) ? bfl_pkg::MAX_OUT : count_i;
    n_in = (NW'(fill_q) < NW'(nreq)) ? 7'(fill_q) : nreq;
  end

  // Line geometry from the LF position (idx_q)
  always_comb begin
    content    = idx_q - FW'(prev_cr_q);
    content_x  = CW'(content);
    if (content_x >= CW'(eff)) begin
      copy       = eff - 7'd1;
      lstat_line = bfl_pkg::ST_TOO_LONG;
    end else begin
      copy       = content_x[6:0];
      lstat_line = bfl_pkg::ST_OK;
    end
    len_line = (content_x > CW'(bfl_pkg::LEN_SAT)) ? bfl_pkg::LEN_SAT : content_x[9:0];
  end

  assign idx_p1    = idx_q + FW'(1);
  assign addr      = wrap({1'b0, base_q} + (AW + 1)'(idx_q));
  assign last_byte = (NW'(idx_p1) == NW'(n_q));

  // Pointer, fill and scan state next values
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    n_d       = n_q;
    prev_cr_d = prev_cr_q;
    len_d     = len_q;
    lstat_d   = lstat_q;
    if (cmd_i.cap) begin
      idx_d     = '0;
      n_d       = n_in;
      prev_cr_d = 1'b0;
      len_d     = '0;
      lstat_d   = bfl_pkg::ST_OK;
    end
    if (cmd_i.clr) begin
      wp_d   = '0;
      rp_d   = '0;
      fill_d = '0;
    end
    if (cmd_i.push) begin
      wp_d   = wrap({1'b0, wp_q} + (AW + 1)'(1));
      fill_d = fill_q + FW'(1);
    end
    if (cmd_i.commit_rd) begin
      rp_d   = wrap({1'b0, rp_q} + (AW + 1)'(n_in));
      fill_d = fill_q - FW'(n_in);
    end
    if (cmd_i.scan_step) begin
      prev_cr_d = (rdata_q == bfl_pkg::CH_CR);
      idx_d     = idx_p1;
    end
    if (cmd_i.line_hit) begin
      rp_d    = wrap({1'b0, rp_q} + (AW + 1)'(idx_p1));
      fill_d  = fill_q - idx_p1;
      n_d     = copy;
      idx_d   = '0;
      len_d   = len_line;
      lstat_d = lstat_line;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
      ov_q   <= 1'b0;
      more_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
      if (cmd_i.out_load) begin
        ov_q   <= 1'b1;
        more_q <= cmd_i.out_data && !last_byte;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Scan and copy working registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    n_q       <= n_d;
    prev_cr_q <= prev_cr_d;
    len_q     <= len_d;
    lstat_q   <= lstat_d;
    if (cmd_i.cap) begin
      base_q <= rp_q;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wp_q] <= in_byte_i;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  assign fill_x = CW'(fill_d);

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      obyte_q <= cmd_i.out_data ? rdata_q : 8'd0;
      obv_q   <= cmd_i.out_data;
      if (cmd_i.out_data) begin
        olast_q <= last_byte;
        ost_q   <= lstat_q;
      end else begin
        olast_q <= cmd_i.out_echo ? in_last_i : 1'b1;
        ost_q   <= cmd_i.out_line ? lstat_d : cmd_i.out_status;
      end
      olen_q  <= len_d;
      ofill_q <= fill_x[10:0];
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.byte_valid = obv_q;
  assign out_o.last       = olast_q;
  assign out_o.status     = ost_q;
  assign out_o.line_len   = olen_q;
  assign out_o.fill_level = ofill_q;

  // Status to controller
  assign st_o.mode      = bfl_pkg::mode_e'(mode_i);
  assign st_o.full      = (fill_q == FILL_MAX);
  assign st_o.n_zero    = (n_in == 7'd0);
  assign st_o.scan_end  = (idx_q == fill_q);
  assign st_o.is_lf     = (rdata_q == bfl_pkg::CH_LF);
  assign st_o.copy_zero = (copy == 7'd0);
  assign st_o.out_taken = ov_q && out_o.ready;
  assign st_o.more      = more_q;

endmodule
